@@ rtl/bsc_pkg.sv @@
// package: payload types, register map and constants of the baro sensor compensation
package bsc_pkg;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } t_bsc_in;

    typedef struct packed {
        logic signed [23:0] temperature_out;
        logic [22:0]        pressure_out;
        logic               clipped;
    } t_bsc_out;

    typedef enum logic [1:0] {
        REG_TRIM_LOW  = 2'd0,
        REG_TRIM_MID  = 2'd1,
        REG_TRIM_HIGH = 2'd2
    } t_bsc_reg;

    localparam int ADDR_W     = 5;
    localparam int LATENCY    = 12;
    localparam int TEMP_MIN   = -2621440;
    localparam int TEMP_MAX   = 5570560;
    localparam int PRESS_MAX  = 8388607;
    localparam int P_OFFSET   = 16384;

endpackage

@@ rtl/baro_sensor_compensation.sv @@
// top level: pipelined barometric temperature and pressure compensation
//
// One raw reading is taken in every clock cycle (busy is high only while
// reset is applied) and its compensated temperature, pressure and clip flag
// appear on o_result with o_valid high for exactly one cycle. The pipeline is
// a chain of registered multipliers: the quadratic temperature polynomial,
// then a Horner evaluation of the pressure cubic in temperature, where h2 * t
// and h1 * t are split into partial products at 32-bit boundaries. The
// receiver cannot stall the results. Calibration words are to be written over
// the APB port while no reading is in flight; the block does not enforce this.
module baro_sensor_compensation (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  bsc_pkg::t_bsc_in        i_item,
    output logic                    o_valid,
    output bsc_pkg::t_bsc_out       o_result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [bsc_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]             pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);
    import bsc_pkg::*;

    logic [63:0] r_trim_low;
    logic [63:0] r_trim_mid;
    logic [39:0] r_trim_high;
    t_bsc_reg    reg_sel;

    // decoded coefficients
    logic [15:0]        t1, t2, p5, p6;
    logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
    logic signed [15:0] p1, p2, p9;
    logic signed [16:0] p1m, p2m;

    assign pready  = 1'b1;
    assign busy    = ~i_rst_n;
    assign reg_sel = t_bsc_reg'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim_low  <= '0;
            r_trim_mid  <= '0;
            r_trim_high <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_sel)
                REG_TRIM_LOW:  r_trim_low  <= pwdata;
                REG_TRIM_MID:  r_trim_mid  <= pwdata;
                REG_TRIM_HIGH: r_trim_high <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TRIM_LOW:  prdata = r_trim_low;
            REG_TRIM_MID:  prdata = r_trim_mid;
            REG_TRIM_HIGH: prdata = {24'b0, r_trim_high};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        t1  = r_trim_low[15:0];
        t2  = r_trim_low[31:16];
        t3  = $signed(r_trim_low[39:32]);
        p1  = $signed(r_trim_low[55:40]);
        p2  = $signed({r_trim_mid[7:0], r_trim_low[63:56]});
        p3  = $signed(r_trim_mid[15:8]);
        p4  = $signed(r_trim_mid[23:16]);
        p5  = r_trim_mid[39:24];
        p6  = r_trim_mid[55:40];
        p7  = $signed(r_trim_mid[63:56]);
        p8  = $signed(r_trim_high[7:0]);
        p9  = $signed(r_trim_high[23:8]);
        p10 = $signed(r_trim_high[31:24]);
        p11 = $signed(r_trim_high[39:32]);
        p1m = $signed({p1[15], p1}) - 17'(P_OFFSET);
        p2m = $signed({p2[15], p2}) - 17'(P_OFFSET);
    end

    // valid bits of stages 1..11
    logic [LATENCY-2:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[LATENCY-3:0], start & ~busy};
            o_valid <= r_vld[LATENCY-2];
        end
    end

    // stage 1
    logic [23:0] r_u1, r_r1;
    // stage 2
    logic [23:0]        r_u2;
    logic signed [24:0] r_d2;
    // stage 3
    logic [23:0]        r_u3;
    logic signed [41:0] r_m3, r_ua3, r_ub3;
    logic signed [49:0] r_dd3;
    logic [47:0]        r_uu3;
    logic signed [32:0] r_uc3, r_ud3;
    // stage 4
    logic signed [41:0] r_m4, r_ua4, r_ub4;
    logic signed [57:0] r_q4;
    logic [47:0]        r_u3lo4, r_u3hi4;
    logic signed [64:0] r_uu9_4;
    logic signed [56:0] r_uu10_4;
    logic signed [32:0] r_uc4, r_ud4;
    // stage 5
    logic signed [59:0] n5;
    logic signed [27:0] tw5;
    logic signed [23:0] r_t5;
    logic               r_ct5;
    logic [71:0]        r_u3_5;
    logic signed [41:0] r_ua5, r_ub5;
    logic signed [32:0] r_uc5, r_ud5;
    logic signed [64:0] r_uu9_5;
    logic signed [56:0] r_uu10_5;
    // stage 6
    logic signed [33:0] c3;
    logic signed [55:0] c2;
    logic signed [83:0] c1;
    logic signed [57:0] r_pt6;
    logic signed [80:0] r_e6;
    logic signed [55:0] r_c2_6;
    logic signed [83:0] r_c1_6;
    logic signed [41:0] r_ua6;
    logic signed [64:0] r_uu9_6;
    logic signed [23:0] r_t6;
    logic               r_ct6;
    // stage 7
    logic signed [109:0] c0;
    logic signed [59:0]  r_h2_7;
    logic signed [109:0] r_c0_7;
    logic signed [83:0]  r_c1_7;
    logic signed [23:0]  r_t7;
    logic                r_ct7;
    // stage 8
    logic signed [56:0]  r_a8;
    logic signed [51:0]  r_b8;
    logic signed [109:0] r_c0_8;
    logic signed [83:0]  r_c1_8;
    logic signed [23:0]  r_t8;
    logic                r_ct8;
    // stage 9
    logic signed [85:0]  r_h1_9;
    logic signed [109:0] r_c0_9;
    logic signed [23:0]  r_t9;
    logic                r_ct9;
    // stage 10
    logic signed [56:0]  r_a0_10, r_a1_10;
    logic signed [45:0]  r_a2_10;
    logic signed [109:0] r_c0_10;
    logic signed [23:0]  r_t10;
    logic                r_ct10;
    // stage 11
    logic signed [109:0] r_s11;
    logic signed [23:0]  r_t11;
    logic                r_ct11;

    always_comb begin
        n5  = $signed({r_m4, 18'b0}) + $signed({{2{r_q4[57]}}, r_q4});
        tw5 = n5[59:32];
        c3  = $signed({{4{p8[7]}}, p8, 22'b0}) + $signed({r_ud5[32], r_ud5});
        c2  = $signed({{3{p7[7]}}, p7, 45'b0})
            + $signed({{2{r_uc5[32]}}, r_uc5, 21'b0});
        c1  = $signed({5'b0, p6, 63'b0})
            + $signed({{2{r_ub5[41]}}, r_ub5, 40'b0})
            + $signed({{6{r_uu10_5[56]}}, r_uu10_5, 21'b0});
        c0  = $signed({6'b0, p5, 88'b0})
            + $signed({{3{r_ua6[41]}}, r_ua6, 65'b0})
            + $signed({{8{r_uu9_6[64]}}, r_uu9_6, 37'b0})
            + $signed({{9{r_e6[80]}}, r_e6, 20'b0});
    end

    always_ff @(posedge i_clk) begin
        // stage 1: capture reading
        r_u1 <= i_item.raw_pressure;
        r_r1 <= i_item.raw_temperature;
        // stage 2: temperature offset
        r_u2 <= r_u1;
        r_d2 <= $signed({1'b0, r_r1}) - $signed({1'b0, t1, 8'b0});
        // stage 3: first products
        r_u3  <= r_u2;
        r_m3  <= r_d2 * $signed({1'b0, t2});
        r_dd3 <= r_d2 * r_d2;
        r_uu3 <= r_u2 * r_u2;
        r_ua3 <= $signed({1'b0, r_u2}) * p1m;
        r_ub3 <= $signed({1'b0, r_u2}) * p2m;
        r_uc3 <= $signed({1'b0, r_u2}) * p3;
        r_ud3 <= $signed({1'b0, r_u2}) * p4;
        // stage 4
        r_m4     <= r_m3;
        r_q4     <= r_dd3 * t3;
        r_u3lo4  <= r_uu3[23:0] * r_u3;
        r_u3hi4  <= r_uu3[47:24] * r_u3;
        r_uu9_4  <= $signed({1'b0, r_uu3}) * p9;
        r_uu10_4 <= $signed({1'b0, r_uu3}) * p10;
        r_ua4    <= r_ua3;
        r_ub4    <= r_ub3;
        r_uc4    <= r_uc3;
        r_ud4    <= r_ud3;
        // stage 5: temperature floor and saturation
        if (tw5 < TEMP_MIN) begin
            r_t5  <= 24'(TEMP_MIN);
            r_ct5 <= 1'b1;
        end else if (tw5 > TEMP_MAX) begin
            r_t5  <= 24'(TEMP_MAX);
            r_ct5 <= 1'b1;
        end else begin
            r_t5  <= tw5[23:0];
            r_ct5 <= 1'b0;
        end
        r_u3_5   <= {r_u3hi4, 24'b0} + {24'b0, r_u3lo4};
        r_ua5    <= r_ua4;
        r_ub5    <= r_ub4;
        r_uc5    <= r_uc4;
        r_ud5    <= r_ud4;
        r_uu9_5  <= r_uu9_4;
        r_uu10_5 <= r_uu10_4;
        // stage 6: cubic coefficient times temperature
        r_pt6   <= c3 * r_t5;
        r_e6    <= $signed({1'b0, r_u3_5}) * p11;
        r_c2_6  <= c2;
        r_c1_6  <= c1;
        r_ua6   <= r_ua5;
        r_uu9_6 <= r_uu9_5;
        r_t6    <= r_t5;
        r_ct6   <= r_ct5;
        // stage 7
        r_h2_7 <= $signed({{2{r_pt6[57]}}, r_pt6}) + $signed({{4{r_c2_6[55]}}, r_c2_6});
        r_c0_7 <= c0;
        r_c1_7 <= r_c1_6;
        r_t7   <= r_t6;
        r_ct7  <= r_ct6;
        // stage 8: partial products of h2 * t
        r_a8   <= $signed({1'b0, r_h2_7[31:0]}) * r_t7;
        r_b8   <= $signed(r_h2_7[59:32]) * r_t7;
        r_c0_8 <= r_c0_7;
        r_c1_8 <= r_c1_7;
        r_t8   <= r_t7;
        r_ct8  <= r_ct7;
        // stage 9
        r_h1_9 <= $signed({{2{r_b8[51]}}, r_b8, 32'b0})
                + $signed({{29{r_a8[56]}}, r_a8})
                + $signed({{2{r_c1_8[83]}}, r_c1_8});
        r_c0_9 <= r_c0_8;
        r_t9   <= r_t8;
        r_ct9  <= r_ct8;
        // stage 10: partial products of h1 * t
        r_a0_10 <= $signed({1'b0, r_h1_9[31:0]}) * r_t9;
        r_a1_10 <= $signed({1'b0, r_h1_9[63:32]}) * r_t9;
        r_a2_10 <= $signed(r_h1_9[85:64]) * r_t9;
        r_c0_10 <= r_c0_9;
        r_t10   <= r_t9;
        r_ct10  <= r_ct9;
        // stage 11: pressure scaled by 2^85
        r_s11  <= $signed({r_a2_10, 64'b0})
                + $signed({{21{r_a1_10[56]}}, r_a1_10, 32'b0})
                + $signed({{53{r_a0_10[56]}}, r_a0_10})
                + r_c0_10;
        r_t11  <= r_t10;
        r_ct11 <= r_ct10;
        // stage 12: pressure floor and saturation
        o_result.temperature_out <= r_t11;
        if (r_s11[109]) begin
            o_result.pressure_out <= '0;
            o_result.clipped      <= 1'b1;
        end else if (|r_s11[108:102]) begin
            o_result.pressure_out <= 23'(PRESS_MAX);
            o_result.clipped      <= 1'b1;
        end else begin
            o_result.pressure_out <= r_s11[101:79];
            o_result.clipped      <= r_ct11;
        end
    end

endmodule

@@ rtl/bsc_checker.sv @@
// checker: port-level assertions of the compensation pipeline, bound to the top level
module bsc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input bsc_pkg::t_bsc_out o_result
);
    import bsc_pkg::*;

    // every accepted transaction yields a result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("missing result after accepted transaction");

    // no result without a transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LATENCY !o_valid)
        else $error("result without transaction");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_result.temperature_out) >= TEMP_MIN
                     && $signed(o_result.temperature_out) <= TEMP_MAX))
        else $error("temperature out of range");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);

@@ dv/baro_sensor_compensation_tb.sv @@
// testbench: random and directed readings against a bit-exact compensation predictor
module baro_sensor_compensation_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bsc_pkg::*;

    typedef logic signed [191:0] t_wide;

    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_bsc_in              i_item;
    logic                 o_valid;
    t_bsc_out             o_result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [63:0]          pwdata;
    logic [63:0]          prdata;
    logic                 pready;

    baro_sensor_compensation u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // testbench copy of the calibration words
    logic [63:0] trim_low;
    logic [63:0] trim_mid;
    logic [39:0] trim_high;

    t_bsc_in  readings_q[$];
    t_bsc_out compensated_q[$];
    int       idle_pct;
    int       errors = 0;
    int       readings_sent = 0;
    int       results_seen = 0;
    int       clipped_seen = 0;
    int       cycles = 0;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [7:0] trim_byte(int i);
        logic [63:0] w;
        w = (i < 8) ? trim_low : (i < 16) ? trim_mid : {24'd0, trim_high};
        return w[(i % 8) * 8 +: 8];
    endfunction

    function automatic longint coef_u16(int i);
        return longint'({48'd0, trim_byte(i + 1), trim_byte(i)});
    endfunction

    function automatic longint coef_s16(int i);
        logic signed [15:0] v;
        v = {trim_byte(i + 1), trim_byte(i)};
        return longint'(v);
    endfunction

    function automatic longint coef_s8(int i);
        logic signed [7:0] v;
        v = trim_byte(i);
        return longint'(v);
    endfunction

    function automatic t_bsc_out compensate(t_bsc_in x);
        longint   d, n, t, t1, t2, t3;
        t_wide    p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11, tw, uw, s;
        logic [48:0] pr;
        bit       clip;
        t_bsc_out r;
        t1 = coef_u16(0);
        t2 = coef_u16(2);
        t3 = coef_s8(4);
        p1 = t_wide'(coef_s16(5));
        p2 = t_wide'(coef_s16(7));
        p3 = t_wide'(coef_s8(9));
        p4 = t_wide'(coef_s8(10));
        p5 = t_wide'(coef_u16(11));
        p6 = t_wide'(coef_u16(13));
        p7 = t_wide'(coef_s8(15));
        p8 = t_wide'(coef_s8(16));
        p9 = t_wide'(coef_s16(17));
        p10 = t_wide'(coef_s8(19));
        p11 = t_wide'(coef_s8(20));
        clip = 1'b0;
        d = longint'({40'd0, x.raw_temperature}) - t1 * 256;
        n = d * t2 * 262144 + d * d * t3;
        t = n >>> 32;
        if (t < TEMP_MIN) begin
            t = longint'(TEMP_MIN);
            clip = 1'b1;
        end
        if (t > TEMP_MAX) begin
            t = longint'(TEMP_MAX);
            clip = 1'b1;
        end
        tw = t_wide'(t);
        uw = t_wide'({168'd0, x.raw_pressure});
        // pressure scaled by 2^85, exact
        s = (p5 <<< 88) + ((p6 * tw) <<< 63) + ((p7 * tw * tw) <<< 45)
          + ((p8 * tw * tw * tw) <<< 22) + ((uw * (p1 - P_OFFSET)) <<< 65)
          + ((uw * (p2 - P_OFFSET) * tw) <<< 40) + ((uw * p3 * tw * tw) <<< 21)
          + (uw * p4 * tw * tw * tw) + ((uw * uw * p9) <<< 37)
          + ((uw * uw * p10 * tw) <<< 21) + ((uw * uw * uw * p11) <<< 20);
        if (s[127]) begin
            pr = '0;
            clip = 1'b1;
        end else begin
            pr = s[127:79];
            if (pr > PRESS_MAX) begin
                pr = 49'(PRESS_MAX);
                clip = 1'b1;
            end
        end
        r.temperature_out = t[23:0];
        r.pressure_out = pr[22:0];
        r.clipped = clip;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_item <= '0;
        end else begin
            if (start && !busy) begin
                compensated_q.push_back(compensate(i_item));
                readings_sent++;
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (readings_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_item <= readings_q.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (compensated_q.size() == 0) begin
                $error("result with no transaction pending: %p", o_result);
                errors++;
            end else begin
                t_bsc_out e;
                e = compensated_q.pop_front();
                results_seen++;
                if (e.clipped) clipped_seen++;
                if (o_result.temperature_out !== e.temperature_out) begin
                    $error("temperature_out expected %0d got %0d",
                           e.temperature_out, o_result.temperature_out);
                    errors++;
                end
                if (o_result.pressure_out !== e.pressure_out) begin
                    $error("pressure_out expected %0d got %0d",
                           e.pressure_out, o_result.pressure_out);
                    errors++;
                end
                if (o_result.clipped !== e.clipped) begin
                    $error("clipped expected %0b got %0b", e.clipped, o_result.clipped);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("baro_sensor_compensation_tb: done, errors");
            $finish;
        end
    end

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [63:0] data);
        logic [63:0] rd_exp;
        bit          mapped;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mapped = 1'b1;
        rd_exp = '0;
        case (addr)
            ADDR_W'(8 * REG_TRIM_LOW): begin
                trim_low = data;
                rd_exp = trim_low;
            end
            ADDR_W'(8 * REG_TRIM_MID): begin
                trim_mid = data;
                rd_exp = trim_mid;
            end
            ADDR_W'(8 * REG_TRIM_HIGH): begin
                trim_high = data[39:0];
                rd_exp = {24'd0, trim_high};
            end
            default: mapped = 1'b0;
        endcase
        // read back the register just written
        @(posedge i_clk);
        if (mapped && prdata !== rd_exp) begin
            $error("prdata expected %0h got %0h", rd_exp, prdata);
            errors++;
        end
    endtask

    task automatic load_trim(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi);
        apb_write(ADDR_W'(8 * REG_TRIM_LOW), lo);
        apb_write(ADDR_W'(8 * REG_TRIM_MID), mid);
        apb_write(ADDR_W'(8 * REG_TRIM_HIGH), hi);
    endtask

    // block until every queued reading has been compensated and checked
    task automatic drain();
        while (readings_q.size() > 0 || start || compensated_q.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_bsc_in random_reading();
        t_bsc_in x;
        int      sel;
        sel = $urandom_range(9);
        x.raw_pressure = 24'($urandom());
        x.raw_temperature = 24'($urandom());
        // mostly near the calibration point, so temperature stays in range
        if (sel < 7) begin
            x.raw_temperature = 24'(coef_u16(0) * 256 + $signed($urandom_range(1200000)) - 600000);
            if (sel < 3) x.raw_pressure = 24'($urandom_range(9000000, 5000000));
        end
        return x;
    endfunction

    task automatic run_random(int count, int pct);
        idle_pct = pct;
        repeat (count) readings_q.push_back(random_reading());
        drain();
    endtask

    initial begin
        t_bsc_in x;
        logic [23:0] edges[4];
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        trim_low = '0;
        trim_mid = '0;
        trim_high = '0;
        idle_pct = 0;
        edges = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // untrimmed: every coefficient zero
        foreach (edges[i]) begin
            x.raw_pressure = edges[i];
            x.raw_temperature = edges[3 - i];
            readings_q.push_back(x);
        end
        drain();

        // typical trim: T1 27000, T2 19000, T3 -7, P1 -4000, P2 -2500, P5 25000, P6 30000
        load_trim(64'h3C_F060_F9_4A38_6978, 64'hF6_7530_61A8_FB_23_F6,
                  64'hFFFF_FF_F5_E0_0F_1C_01);
        foreach (edges[i])
            foreach (edges[j]) begin
                x.raw_pressure = edges[i];
                x.raw_temperature = edges[j];
                readings_q.push_back(x);
            end
        x.raw_temperature = 24'(27000 * 256);
        x.raw_pressure = 24'd7000000;
        readings_q.push_back(x);
        drain();
        // writes to an unmapped address must leave the trim alone
        apb_write(ADDR_W'(24), 64'hDEAD_BEEF_0123_4567);

        run_random(200, 0);
        run_random(100, 71);
        // sender holds off until every result is back, then resumes
        run_random(100, 71);
        run_random(200, 13);

        // all-ones trim
        load_trim('1, '1, '1);
        run_random(100, 0);
        run_random(60, 71);

        repeat (4) begin
            load_trim({$urandom(), $urandom()}, {$urandom(), $urandom()},
                      {$urandom(), $urandom()});
            run_random(80, $urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? 71 : 13));
        end

        load_trim(64'h3C_F060_F9_4A38_6978, 64'hF6_7530_61A8_FB_23_F6, 64'h00_F5_E0_0F_1C_01);
        run_random(150, 13);
        load_trim('0, '0, '0);
        run_random(20, 71);

        $display("sent %0d readings, compensated %0d, %0d saturated, across 9 trim settings",
                 readings_sent, results_seen, clipped_seen);
        if (compensated_q.size() > 0) begin
            $error("%0d expected results never arrived", compensated_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("baro_sensor_compensation_tb: done, clean");
        end else begin
            $display("baro_sensor_compensation_tb: done, errors");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/bsc_pkg.sv
rtl/baro_sensor_compensation.sv
rtl/bsc_checker.sv
dv/baro_sensor_compensation_tb.sv
